// ===== src/xcr_pkg.sv =====
// Package with the shared types, codes and the CRC helper of the XMODEM-CRC receiver.
`default_nettype none
package xcr_pkg;

    localparam int PAYLOAD_BYTES_DEF = 128;
    localparam int COUNT_W           = 24;
    localparam int CFG_DATA_W        = 4;

    // Commands of an input beat.
    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_RETRY_LIMIT      = 1'b0;
    localparam logic CFG_TIMEOUTS_PER_NAK = 1'b1;

    // Protocol bytes.
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    // Packet verdicts.
    localparam logic [1:0] VERDICT_NONE      = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED  = 2'd1;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;
    localparam logic [1:0] VERDICT_REJECTED  = 2'd3;

    // Transfer status.
    localparam logic [1:0] STATUS_RUNNING  = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ABORTED  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR   = 4'd1,
        PH_SEQ   = 4'd2,
        PH_INV   = 4'd3,
        PH_DATA  = 4'd4,
        PH_CRCH  = 4'd5,
        PH_CRCL  = 4'd6,
        PH_CAN1  = 4'd7,
        PH_CAN2  = 4'd8,
        PH_DONE  = 4'd9,
        PH_ABORT = 4'd10
    } t_phase;

    // What the engine emits for one beat.
    typedef enum logic [2:0] {
        ACT_QUIET  = 3'd0,
        ACT_SEND_C = 3'd1,
        ACT_NAK    = 3'd2,
        ACT_ACK    = 3'd3,
        ACT_DATA   = 3'd4
    } t_action;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } t_cmd_beat;

    typedef struct packed {
        logic               tx_valid;
        logic [7:0]         tx_byte;
        logic               data_valid;
        logic [7:0]         data_byte;
        logic [1:0]         verdict;
        logic [1:0]         status;
        logic [COUNT_W-1:0] byte_count;
    } t_result;

    // CRC-16/XMODEM update by one byte, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/xcr_cmd_if.sv =====
// Interface of the command channel: valid, ready and the command beat fields.
`default_nettype none
interface xcr_cmd_if import xcr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== src/xcr_res_if.sv =====
// Interface of the result channel: valid, ready and the result beat fields.
`default_nettype none
interface xcr_res_if import xcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               data_valid;
    logic [7:0]         data_byte;
    logic [1:0]         verdict;
    logic [1:0]         status;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, output tx_valid, output tx_byte, output data_valid,
                    output data_byte, output verdict, output status, output byte_count,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input data_valid,
                    input data_byte, input verdict, input status, input byte_count,
                    output ready);
endinterface
`default_nettype wire

// ===== src/xmodem_crc_receiver_top.sv =====
// Top level of the XMODEM-CRC receiver: channels, configuration registers and checks.
//
// XMODEM-CRC receiver for 128-byte packets. Each command beat is a start command, one
// received serial byte or a receive timeout. A beat produces at most one result beat,
// which carries a reply byte to send ('C', ACK or NAK), a payload byte forwarded
// tentatively, the verdict on a packet when its last CRC byte, a timeout or a start
// ends it (accepted, duplicate or rejected), the transfer status after the beat and the
// saturating count of accepted payload bytes. Quiet beats (header, sequence,
// complement, CRC high and leading CAN bytes, header timeouts below the threshold, and
// bytes or timeouts while idle, complete or aborted) give no result beat. The block
// takes one command beat per cycle: a beat is registered at the input and passes the
// engine into the output register when that has room. The combinational engine step,
// with its byte-wide CRC update, sets that rate; back-pressure on the result channel
// stalls the input only when a result is waiting and cannot move. Configuration (retry
// limit at index 0, header timeouts per NAK at index 1) is written by the user through
// the plain write port only while the block is idle; the block does not enforce this.
`default_nettype none
module xmodem_crc_receiver_top import xcr_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    xcr_cmd_if.sink               i_cmd,
    xcr_res_if.source             o_res,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);
    logic [3:0] r_retry_limit;
    logic [2:0] r_timeouts_per_nak;

    logic       w_in_valid;
    t_cmd_beat  w_in_beat;
    logic       w_room;
    logic       w_fire;
    logic       w_has_result;
    t_result    w_result;

    // Configuration registers; reset values give four retries and three timeouts per NAK.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit      <= 4'd4;
            r_timeouts_per_nak <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_LIMIT:      r_retry_limit      <= i_cfg_data[3:0];
                CFG_TIMEOUTS_PER_NAK: r_timeouts_per_nak <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // The engine moves a beat when the output register has room for its result.
    assign w_fire = w_in_valid && w_room;

    xcr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_beat  (w_in_beat)
    );

    xcr_engine #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (w_fire),
        .i_beat             (w_in_beat),
        .i_retry_limit      (r_retry_limit),
        .i_timeouts_per_nak (r_timeouts_per_nak),
        .o_has_result       (w_has_result),
        .o_result           (w_result)
    );

    xcr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_has_result),
        .i_result (w_result),
        .o_room   (w_room),
        .o_res    (o_res)
    );

    // An aborted transfer reports a cleared byte count.
    a_abort_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == STATUS_ABORTED |-> o_res.byte_count == '0)
        else $error("aborted result with nonzero byte count");

    // A verdict always comes with a reply byte.
    a_verdict_has_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.verdict != VERDICT_NONE |-> o_res.tx_valid)
        else $error("verdict without reply byte");

    // Payload forwarding and a reply byte never share one result beat.
    a_data_excludes_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data_valid |-> !o_res.tx_valid && o_res.verdict == VERDICT_NONE)
        else $error("payload byte mixed with reply");

    // Reply bytes are only 'C', ACK or NAK.
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.tx_valid |->
            o_res.tx_byte == B_C || o_res.tx_byte == B_ACK || o_res.tx_byte == B_NAK)
        else $error("unexpected reply byte");

    // A completed engine step with a result must find the output register free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_has_result && o_res.valid |-> o_res.ready)
        else $error("result register overwritten");
endmodule
`default_nettype wire

// ===== src/xcr_in_stage.sv =====
// Input register that captures one command beat and holds it until the engine takes it.
`default_nettype none
module xcr_in_stage import xcr_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    xcr_cmd_if.sink    i_cmd,
    input  wire        i_take,
    output logic       o_valid,
    output t_cmd_beat  o_beat
);
    logic      r_valid;
    t_cmd_beat r_beat;

    assign i_cmd.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_beat.command <= i_cmd.command;
            r_beat.rx_byte <= i_cmd.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
endmodule
`default_nettype wire

// ===== src/xcr_engine.sv =====
// Protocol engine: receiver state, packet checks and the result of each beat.
`default_nettype none
module xcr_engine import xcr_pkg::*; #(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  t_cmd_beat  i_beat,
    input  wire [3:0]  i_retry_limit,
    input  wire [2:0]  i_timeouts_per_nak,
    output logic       o_has_result,
    output t_result    o_result
);
    localparam int IDX_W = $clog2(PAYLOAD_BYTES + 1);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_expected, n_expected;
    logic [3:0]         r_retry, n_retry;
    logic [2:0]         r_tmo, n_tmo;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_seq, n_seq;
    logic [7:0]         r_seq_inv, n_seq_inv;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_crc_hi, n_crc_hi;
    logic [COUNT_W-1:0] r_acc, n_acc;

    t_action            w_action;
    logic [1:0]         w_verdict;
    logic               w_nak_retry;
    logic [4:0]         w_retry_inc;
    logic [3:0]         w_tmo_inc;
    logic [IDX_W-1:0]   w_idx_inc;
    logic [COUNT_W:0]   w_acc_sum;
    logic               w_in_packet;
    logic               w_dup;
    logic               w_bad;

    assign w_retry_inc = {1'b0, r_retry} + 5'd1;
    assign w_tmo_inc   = {1'b0, r_tmo} + 4'd1;
    assign w_idx_inc   = r_idx + IDX_W'(1);
    assign w_acc_sum   = {1'b0, r_acc} + (COUNT_W+1)'(PAYLOAD_BYTES);
    assign w_in_packet = (r_phase == PH_SEQ) || (r_phase == PH_INV) || (r_phase == PH_DATA)
                      || (r_phase == PH_CRCH) || (r_phase == PH_CRCL);
    assign w_dup = (r_seq < r_expected) && (r_seq_inv == ~r_seq);
    assign w_bad = (r_seq != r_expected) || (r_seq_inv != ~r_expected)
                || ({r_crc_hi, i_beat.rx_byte} != r_crc);

    // Next state and the action of this beat.
    always_comb begin
        n_phase     = r_phase;
        n_expected  = r_expected;
        n_retry     = r_retry;
        n_tmo       = r_tmo;
        n_idx       = r_idx;
        n_seq       = r_seq;
        n_seq_inv   = r_seq_inv;
        n_crc       = r_crc;
        n_crc_hi    = r_crc_hi;
        n_acc       = r_acc;
        w_action    = ACT_QUIET;
        w_verdict   = VERDICT_NONE;
        w_nak_retry = 1'b0;

        if (i_beat.command == CMD_START) begin
            if (w_in_packet) begin
                w_verdict = VERDICT_REJECTED;
            end
            n_expected = 8'd1;
            n_retry    = 4'd0;
            n_acc      = '0;
            n_phase    = PH_HDR;
            n_tmo      = 3'd0;
            w_action   = ACT_SEND_C;
        end else if (i_beat.command == CMD_TIMEOUT) begin
            if (r_phase == PH_HDR) begin
                if (w_tmo_inc < {1'b0, i_timeouts_per_nak}) begin
                    n_tmo = w_tmo_inc[2:0];
                end else begin
                    w_nak_retry = 1'b1;
                end
            end else if (w_in_packet) begin
                w_verdict   = VERDICT_REJECTED;
                w_nak_retry = 1'b1;
            end else if (r_phase == PH_CAN1 || r_phase == PH_CAN2) begin
                w_nak_retry = 1'b1;
            end
        end else if (i_beat.command == CMD_BYTE) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (i_beat.rx_byte == B_EOT) begin
                        w_action = ACT_ACK;
                        n_retry  = 4'd0;
                        n_phase  = PH_DONE;
                    end else if (i_beat.rx_byte == B_SOH) begin
                        n_phase = PH_SEQ;
                        n_idx   = '0;
                        n_crc   = 16'h0000;
                    end else if (i_beat.rx_byte == B_CAN) begin
                        n_phase = PH_CAN1;
                    end else begin
                        w_nak_retry = 1'b1;
                    end
                end
                PH_CAN1, PH_CAN2: begin
                    if (i_beat.rx_byte != B_CAN) begin
                        w_nak_retry = 1'b1;
                    end else if (r_phase == PH_CAN1) begin
                        n_phase = PH_CAN2;
                    end else begin
                        w_action = ACT_ACK;
                        n_phase  = PH_ABORT;
                        n_acc    = '0;
                    end
                end
                PH_SEQ: begin
                    n_seq   = i_beat.rx_byte;
                    n_phase = PH_INV;
                end
                PH_INV: begin
                    n_seq_inv = i_beat.rx_byte;
                    n_phase   = PH_DATA;
                end
                PH_DATA: begin
                    w_action = ACT_DATA;
                    n_crc    = crc_update(r_crc, i_beat.rx_byte);
                    n_idx    = w_idx_inc;
                    if (w_idx_inc >= IDX_W'(PAYLOAD_BYTES)) begin
                        n_phase = PH_CRCH;
                    end
                end
                PH_CRCH: begin
                    n_crc_hi = i_beat.rx_byte;
                    n_phase  = PH_CRCL;
                end
                PH_CRCL: begin
                    if (w_dup) begin
                        w_action  = ACT_ACK;
                        w_verdict = VERDICT_DUPLICATE;
                        n_retry   = 4'd0;
                        n_phase   = PH_HDR;
                        n_tmo     = 3'd0;
                    end else if (w_bad) begin
                        w_verdict   = VERDICT_REJECTED;
                        w_nak_retry = 1'b1;
                    end else begin
                        w_action   = ACT_ACK;
                        w_verdict  = VERDICT_ACCEPTED;
                        n_acc      = w_acc_sum[COUNT_W] ? '1 : w_acc_sum[COUNT_W-1:0];
                        n_expected = r_expected + 8'd1;
                        n_retry    = 4'd0;
                        n_phase    = PH_HDR;
                        n_tmo      = 3'd0;
                    end
                end
                default: begin
                    // Idle, complete and aborted ignore received bytes.
                end
            endcase
        end

        // A NAK counts as a retry; one past the limit aborts the transfer.
        if (w_nak_retry) begin
            w_action = ACT_NAK;
            if (w_retry_inc > {1'b0, i_retry_limit}) begin
                n_phase = PH_ABORT;
                n_acc   = '0;
            end else begin
                n_retry = w_retry_inc[3:0];
                n_phase = PH_HDR;
                n_tmo   = 3'd0;
            end
        end
    end

    // Result fields of this beat.
    always_comb begin
        o_result            = '0;
        o_result.verdict    = w_verdict;
        o_result.byte_count = n_acc;
        o_has_result        = (w_action != ACT_QUIET);
        unique case (n_phase)
            PH_DONE:  o_result.status = STATUS_COMPLETE;
            PH_ABORT: o_result.status = STATUS_ABORTED;
            default:  o_result.status = STATUS_RUNNING;
        endcase
        case (w_action)
            ACT_SEND_C: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = B_C;
            end
            ACT_NAK: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = B_NAK;
            end
            ACT_ACK: begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = B_ACK;
            end
            ACT_DATA: begin
                o_result.data_valid = 1'b1;
                o_result.data_byte  = i_beat.rx_byte;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_expected <= 8'd1;
            r_retry    <= 4'd0;
            r_tmo      <= 3'd0;
            r_idx      <= '0;
            r_seq      <= 8'd0;
            r_seq_inv  <= 8'd0;
            r_crc      <= 16'h0000;
            r_crc_hi   <= 8'd0;
            r_acc      <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_retry    <= n_retry;
            r_tmo      <= n_tmo;
            r_idx      <= n_idx;
            r_seq      <= n_seq;
            r_seq_inv  <= n_seq_inv;
            r_crc      <= n_crc;
            r_crc_hi   <= n_crc_hi;
            r_acc      <= n_acc;
        end
    end
endmodule
`default_nettype wire

// ===== src/xcr_out_stage.sv =====
// Result register that holds a finished result beat until the sink takes it.
`default_nettype none
module xcr_out_stage import xcr_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_load,
    input  t_result    i_result,
    output logic       o_room,
    xcr_res_if.source  o_res
);
    logic    r_valid;
    t_result r_result;

    assign o_room = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.tx_valid   = r_result.tx_valid;
    assign o_res.tx_byte    = r_result.tx_byte;
    assign o_res.data_valid = r_result.data_valid;
    assign o_res.data_byte  = r_result.data_byte;
    assign o_res.verdict    = r_result.verdict;
    assign o_res.status     = r_result.status;
    assign o_res.byte_count = r_result.byte_count;
endmodule
`default_nettype wire
